@@ src/dots_pkg.sv @@
// Shared widths, operation codes and stream layouts for the deadline-ordered timer set.
`timescale 1ns / 1ps

package dots_pkg;

  // input item fields
  localparam int OP_W    = 2;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 32;
  localparam int NOW_W   = 48;

  // reported time fields
  localparam int OUT_TIME_W = 48;
  localparam logic [OUT_TIME_W-1:0] OUT_TIME_MAX = '1;

  // a tick fires at most this many timers
  localparam int MAX_FIRE   = 16;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);
  localparam int FIRE_IDX_W = $clog2(MAX_FIRE);

  // stream layouts
  localparam int S_TDATA_RAW = ID_W + DELAY_W + NOW_W;
  localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int M_TDATA_RAW = ID_W + OUT_TIME_W + 1 + 1 + OUT_TIME_W;
  localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

endpackage

@@ src/deadline_ordered_timer_set.sv @@
// Deadline-ordered timer set: slot storage, scan sequencer and result stream.
`timescale 1ns / 1ps

// A fixed set of NUM_TIMERS timer slots, each an absolute deadline of TIME_BITS
// bits and an armed flag. Each input transaction carries the current time and
// one operation: arm (deadline = now + delay, saturated), cancel, tick (fire
// every due timer, earliest deadline first, lower slot first on ties, at most
// 16 per tick) or query. A tick returns one output transaction per fired
// timer, otherwise one output transaction is returned; m_tlast marks the
// final one. Every output transaction of an item carries the same time to the
// earliest armed deadline and the status of the addressed slot, taken after
// the whole item. Deadlines sit in a memory with one write port and one read port
// that is swept by one comparator, one slot per cycle; each fired timer starts
// a fresh sweep. After the last sweep the addressed slot's status is taken and
// the results follow, held while m_tready is low. s_tready is low from the time
// an item is taken until its last result is accepted. Armed flags reset to zero;
// deadline storage needs no clearing pass.
module deadline_ordered_timer_set #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dots_pkg::S_TDATA_W-1:0]      s_tdata,  // timer_id[3:0], delay[35:4], now[83:36]
  input  logic [dots_pkg::OP_W-1:0]           s_tuser,  // operation[1:0]
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dots_pkg::M_TDATA_W-1:0]      m_tdata,  // fired_id[3:0], next_remaining[51:4],
                                                        // timer_armed[52], timer_expired[53],
                                                        // timer_remaining[101:54]
  output logic                                m_tuser,  // fired_valid[0]
  output logic                                m_tlast   // last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SUM_W = ((TIME_BITS > dots_pkg::DELAY_W) ? TIME_BITS : dots_pkg::DELAY_W) + 1;
  localparam int EXT_W = (TIME_BITS > dots_pkg::OUT_TIME_W) ? TIME_BITS : dots_pkg::OUT_TIME_W;
  localparam int OFS_DELAY = dots_pkg::ID_W;
  localparam int OFS_NOW   = dots_pkg::ID_W + dots_pkg::DELAY_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_APPLY  = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_FLUSH  = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_STATUS = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t state;

  // latched item
  dots_pkg::op_t                 op_q;
  logic [dots_pkg::ID_W-1:0]     id_q;
  logic [dots_pkg::DELAY_W-1:0]  delay_q;
  logic [TIME_BITS-1:0]          now_q;

  // slot storage
  logic [NUM_TIMERS-1:0]         armed;
  logic [TIME_BITS-1:0]          deadline_mem [NUM_TIMERS];

  // scan pipeline: read stage then compare stage
  logic [IDX_W-1:0]              scan_addr;
  logic [TIME_BITS-1:0]          rd_data;
  logic [IDX_W-1:0]              rd_slot;
  logic                          rd_live;
  logic                          rd_armed;
  logic                          best_found;
  logic [TIME_BITS-1:0]          best_dl;
  logic [IDX_W-1:0]              best_slot;
  logic [TIME_BITS-1:0]          id_dl;

  // fired timers and results
  logic [dots_pkg::FIRE_CNT_W-1:0] fire_cnt;
  logic [dots_pkg::ID_W-1:0]       fire_list [dots_pkg::MAX_FIRE];
  logic [dots_pkg::FIRE_IDX_W-1:0] emit_idx;
  logic [dots_pkg::OUT_TIME_W-1:0] next_rem;
  logic                            t_armed;
  logic                            t_exp;
  logic [dots_pkg::OUT_TIME_W-1:0] t_rem;

  // combinational helpers
  logic                          id_ok;
  logic [IDX_W-1:0]              id_idx;
  logic [SUM_W-1:0]              sum_full;
  logic [TIME_BITS-1:0]          arm_dl;
  logic [TIME_BITS-1:0]          cmp_dl;
  logic                          cmp_due;
  logic [EXT_W-1:0]              diff_ext;
  logic [dots_pkg::OUT_TIME_W-1:0] diff_sat;
  logic                          fire_now;
  logic                          addr_armed;
  logic                          emit_last;

  assign id_ok  = (32'(id_q) < NUM_TIMERS);
  assign id_idx = IDX_W'(id_q);

  // arm: now + delay, saturated at the deadline range
  assign sum_full = SUM_W'(now_q) + SUM_W'(delay_q);
  assign arm_dl   = (|sum_full[SUM_W-1:TIME_BITS]) ? '1 : sum_full[TIME_BITS-1:0];

  // one subtractor serves the earliest deadline and the addressed slot
  assign cmp_dl   = (state == ST_STATUS) ? id_dl : best_dl;
  assign cmp_due  = (cmp_dl <= now_q);
  assign diff_ext = EXT_W'(cmp_dl - now_q);
  assign diff_sat = (diff_ext > EXT_W'(dots_pkg::OUT_TIME_MAX)) ? dots_pkg::OUT_TIME_MAX
                                                               : diff_ext[dots_pkg::OUT_TIME_W-1:0];

  assign fire_now = (op_q == dots_pkg::OP_TICK) && best_found && cmp_due &&
                    (fire_cnt != dots_pkg::FIRE_CNT_W'(dots_pkg::MAX_FIRE));
  assign addr_armed = id_ok && armed[id_idx];

  assign emit_last = (fire_cnt == '0) ||
                     (dots_pkg::FIRE_CNT_W'(emit_idx) + 1'b1 == fire_cnt);

  // deadline memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_APPLY && op_q == dots_pkg::OP_ARM && id_ok) begin
      deadline_mem[id_idx] <= arm_dl;
    end
    rd_data <= deadline_mem[scan_addr];
  end

  // item capture and compare-stage payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      op_q    <= dots_pkg::op_t'(s_tuser);
      id_q    <= s_tdata[dots_pkg::ID_W-1:0];
      delay_q <= s_tdata[OFS_DELAY +: dots_pkg::DELAY_W];
      now_q   <= TIME_BITS'(s_tdata[OFS_NOW +: dots_pkg::NOW_W]);
    end
    rd_slot  <= scan_addr;
    rd_armed <= armed[scan_addr];
    if (rd_live) begin
      if (rd_armed && (!best_found || rd_data < best_dl)) begin
        best_dl   <= rd_data;
        best_slot <= rd_slot;
      end
      if (rd_slot == id_idx) begin
        id_dl <= rd_data;
      end
    end
    if (state == ST_DECIDE && fire_now) begin
      fire_list[fire_cnt[dots_pkg::FIRE_IDX_W-1:0]] <= dots_pkg::ID_W'(best_slot);
    end
    if (state == ST_DECIDE) begin
      next_rem <= (best_found && !cmp_due) ? diff_sat : '0;
    end
    if (state == ST_STATUS) begin
      t_armed <= addr_armed;
      t_exp   <= addr_armed && cmp_due;
      t_rem   <= (addr_armed && !cmp_due) ? diff_sat : '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      armed      <= '0;
      scan_addr  <= '0;
      rd_live    <= 1'b0;
      best_found <= 1'b0;
      fire_cnt   <= '0;
      emit_idx   <= '0;
    end else begin
      rd_live <= (state == ST_SCAN);
      if (rd_live && rd_armed) begin
        best_found <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (op_q == dots_pkg::OP_ARM && id_ok) begin
            armed[id_idx] <= 1'b1;
          end else if (op_q == dots_pkg::OP_CANCEL && id_ok) begin
            armed[id_idx] <= 1'b0;
          end
          fire_cnt   <= '0;
          scan_addr  <= '0;
          best_found <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_addr == IDX_W'(NUM_TIMERS - 1)) begin
            state <= ST_FLUSH;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_FLUSH: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (fire_now) begin
            // fire the earliest due timer and rescan
            armed[best_slot] <= 1'b0;
            fire_cnt   <= fire_cnt + 1'b1;
            scan_addr  <= '0;
            best_found <= 1'b0;
            state      <= ST_SCAN;
          end else begin
            state <= ST_STATUS;
          end
        end
        ST_STATUS: begin
          emit_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (emit_last) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tuser  = (fire_cnt != '0);
  assign m_tlast  = emit_last;
  assign m_tdata  = {
    (dots_pkg::M_TDATA_W - dots_pkg::M_TDATA_RAW)'(0),
    t_rem,
    t_exp,
    t_armed,
    next_rem,
    (fire_cnt != '0) ? fire_list[emit_idx] : dots_pkg::ID_W'(0)
  };

endmodule

@@ tb/tb.sv @@
// Self-checking regression for the deadline-ordered timer set, driven over its stream ports.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_SLOTS = 16;
  localparam int TIME_W    = 48;
  // Extra wait after the final drain, longer than the worst item waits for its first result.
  localparam int SETTLE_CYCLES = 400;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  localparam logic [dots_pkg::NOW_W-1:0]   NOW_MAX   = '1;
  localparam logic [dots_pkg::DELAY_W-1:0] DELAY_MAX = '1;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_style_t;

  // One result transaction as the block should produce it.
  typedef struct {
    bit                            fired_valid;
    bit [dots_pkg::ID_W-1:0]       fired_id;
    bit                            last;
    bit [dots_pkg::OUT_TIME_W-1:0] next_remaining;
    bit                            timer_armed;
    bit                            timer_expired;
    bit [dots_pkg::OUT_TIME_W-1:0] timer_remaining;
  } timer_report_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [dots_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic [dots_pkg::OP_W-1:0]      s_tuser  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [dots_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tuser;
  logic                           m_tlast;

  // Shadow copy of the timer slots, updated on every accepted input transaction.
  logic [TIME_W-1:0] deadline_of [NUM_SLOTS];
  bit                armed_of    [NUM_SLOTS];

  timer_report_t               pending_reports[$];
  int                          failures      = 0;
  int                          items_sent    = 0;
  int                          idle_cycles   = 0;
  bit                          bursty_sender = 1'b0;
  int                          burst_left    = 0;
  rx_style_t                   stall_style   = RX_ALWAYS;
  int                          rx_phase      = 0;
  int                          hold_left     = 0;
  logic [dots_pkg::NOW_W-1:0]  wall_ms       = '0;

  deadline_ordered_timer_set #(
    .NUM_TIMERS(NUM_SLOTS),
    .TIME_BITS (TIME_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      deadline_of[i] = '0;
      armed_of[i]    = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Timer set predictor
  // ---------------------------------------------------------------------------

  function automatic logic [TIME_W-1:0] time_until(logic [TIME_W-1:0] due,
                                                   logic [TIME_W-1:0] now);
    return (due > now) ? due - now : '0;
  endfunction

  // Armed slot with the smallest deadline, lower index winning ties; -1 if none.
  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (armed_of[i] && (best < 0 || deadline_of[i] < deadline_of[best])) best = i;
    return best;
  endfunction

  // Applies one operation to the shadow slots and queues the reports it causes.
  function automatic void apply_timer_op(dots_pkg::op_t op, logic [dots_pkg::ID_W-1:0] id,
                                         logic [dots_pkg::DELAY_W-1:0] delay,
                                         logic [dots_pkg::NOW_W-1:0] now);
    logic [TIME_W:0] sum;
    int              fired[$];
    int              e;
    timer_report_t   rep;
    case (op)
      dots_pkg::OP_ARM: begin
        // deadline saturates at the top of the time range
        sum = {1'b0, now} + {{(TIME_W + 1 - dots_pkg::DELAY_W){1'b0}}, delay};
        deadline_of[id] = sum[TIME_W] ? NOW_MAX : sum[TIME_W-1:0];
        armed_of[id]    = 1'b1;
      end
      dots_pkg::OP_CANCEL: begin
        armed_of[id]    = 1'b0;
        deadline_of[id] = '0;
      end
      dots_pkg::OP_TICK: begin
        while (fired.size() < dots_pkg::MAX_FIRE) begin
          e = earliest_armed();
          if (e < 0 || deadline_of[e] > now) break;
          armed_of[e]    = 1'b0;
          deadline_of[e] = '0;
          fired.push_back(e);
        end
      end
      default: ;
    endcase

    // status fields are shared by every report of this item
    rep.next_remaining = '0;
    e = earliest_armed();
    if (e >= 0) rep.next_remaining = time_until(deadline_of[e], now);
    rep.timer_armed     = armed_of[id];
    rep.timer_expired   = armed_of[id] && (deadline_of[id] <= now);
    rep.timer_remaining = armed_of[id] ? time_until(deadline_of[id], now) : '0;

    if (fired.size() == 0) begin
      rep.fired_valid = 1'b0;
      rep.fired_id    = '0;
      rep.last        = 1'b1;
      pending_reports.push_back(rep);
    end else begin
      for (int k = 0; k < fired.size(); k++) begin
        rep.fired_valid = 1'b1;
        rep.fired_id    = dots_pkg::ID_W'(fired[k]);
        rep.last        = (k == fired.size() - 1);
        pending_reports.push_back(rep);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Presents one timer operation and holds it until the block takes the transaction.
  task automatic send_timer_op(dots_pkg::op_t op, logic [dots_pkg::ID_W-1:0] id,
                               logic [dots_pkg::DELAY_W-1:0] delay,
                               logic [dots_pkg::NOW_W-1:0] now);
    logic [dots_pkg::S_TDATA_W-1:0] word;
    int                             gap;
    word = '0;
    word[dots_pkg::ID_W-1:0]                              = id;
    word[dots_pkg::ID_W +: dots_pkg::DELAY_W]             = delay;
    word[dots_pkg::ID_W + dots_pkg::DELAY_W +: dots_pkg::NOW_W] = now;
    if (bursty_sender) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    apply_timer_op(op, id, delay, now);
    items_sent++;
  endtask

  // Holds the input off until every queued report has come back.
  task automatic wait_reports_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: backpressure pattern and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    case (stall_style)
      RX_ALWAYS:   m_tready <= 1'b1;
      RX_RANDOM:   m_tready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: m_tready <= ((rx_phase % 7) < 3);
      default: begin
        // long alternating stretches of ready and stall
        if (hold_left == 0) begin
          m_tready  <= ~m_tready;
          hold_left <= $urandom_range(1, 20);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    timer_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with nothing pending: tuser %0d tdata %h", m_tuser, m_tdata);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("fired_valid", 64'(want.fired_valid), 64'(m_tuser));
        check_field("fired_id", 64'(want.fired_id), 64'(m_tdata[dots_pkg::ID_W-1:0]));
        check_field("last", 64'(want.last), 64'(m_tlast));
        check_field("next_remaining", 64'(want.next_remaining),
                    64'(m_tdata[dots_pkg::ID_W +: dots_pkg::OUT_TIME_W]));
        check_field("timer_armed", 64'(want.timer_armed),
                    64'(m_tdata[dots_pkg::ID_W + dots_pkg::OUT_TIME_W]));
        check_field("timer_expired", 64'(want.timer_expired),
                    64'(m_tdata[dots_pkg::ID_W + dots_pkg::OUT_TIME_W + 1]));
        check_field("timer_remaining", 64'(want.timer_remaining),
                    64'(m_tdata[dots_pkg::ID_W + dots_pkg::OUT_TIME_W + 2 +:
                                dots_pkg::OUT_TIME_W]));
      end
    end
  end

  // Hang detector: counts cycles in which neither side moves a transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("deadline_ordered_timer_set regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty set: status reads zero, a tick fires nothing.
  task automatic test_reset_state();
    send_timer_op(dots_pkg::OP_QUERY, 4'd0, '0, '0);
    send_timer_op(dots_pkg::OP_QUERY, 4'd15, DELAY_MAX, NOW_MAX);
    send_timer_op(dots_pkg::OP_TICK, 4'd0, '0, '0);
  endtask

  // Zero delay is due at once; the widest delay from time zero.
  task automatic test_arm_and_expiry();
    send_timer_op(dots_pkg::OP_ARM, 4'd0, '0, '0);
    send_timer_op(dots_pkg::OP_ARM, 4'd15, DELAY_MAX, '0);
    send_timer_op(dots_pkg::OP_QUERY, 4'd15, '0, 48'd5);
  endtask

  // now + delay past the time range clamps to its top.
  task automatic test_deadline_saturation();
    send_timer_op(dots_pkg::OP_ARM, 4'd7, DELAY_MAX, NOW_MAX - 48'd10);
    send_timer_op(dots_pkg::OP_QUERY, 4'd7, '0, NOW_MAX);
  endtask

  // Re-arm moves the deadline; cancel twice; cancel of a slot never armed.
  task automatic test_rearm_and_cancel();
    send_timer_op(dots_pkg::OP_ARM, 4'd3, 32'd100, 48'd1000);
    send_timer_op(dots_pkg::OP_ARM, 4'd3, 32'd50, 48'd1010);
    send_timer_op(dots_pkg::OP_CANCEL, 4'd3, '0, 48'd1020);
    send_timer_op(dots_pkg::OP_CANCEL, 4'd3, '0, 48'd1030);
    send_timer_op(dots_pkg::OP_CANCEL, 4'd8, DELAY_MAX, 48'd1040);
  endtask

  // Tick with armed timers none of which is due, then equal deadlines by index,
  // then a late tick that fires the far deadlines in deadline order.
  task automatic test_tick_order();
    send_timer_op(dots_pkg::OP_CANCEL, 4'd0, '0, 48'd2000);
    send_timer_op(dots_pkg::OP_ARM, 4'd9, 32'd10, 48'd2000);
    send_timer_op(dots_pkg::OP_ARM, 4'd4, 32'd10, 48'd2000);
    send_timer_op(dots_pkg::OP_ARM, 4'd12, 32'd10, 48'd2000);
    send_timer_op(dots_pkg::OP_TICK, 4'd4, '0, 48'd2005);
    send_timer_op(dots_pkg::OP_TICK, 4'd9, '0, 48'd2010);
    send_timer_op(dots_pkg::OP_TICK, 4'd15, '0, NOW_MAX);
  endtask

  // Every slot armed at once, then one tick fires all sixteen.
  task automatic test_flush_all_slots();
    logic [dots_pkg::NOW_W-1:0] base;
    base = dots_pkg::NOW_W'({$urandom_range(0, 32'h7FFF), $urandom});
    for (int i = 0; i < NUM_SLOTS; i++)
      send_timer_op(dots_pkg::OP_ARM, dots_pkg::ID_W'(i), $urandom_range(0, 3), base);
    send_timer_op(dots_pkg::OP_TICK, dots_pkg::ID_W'($urandom_range(0, 15)), $urandom,
                  base + 48'd1000);
  endtask

  // Mostly time-ordered traffic around a moving clock, with tie groups,
  // arm/cancel pairs and out-of-order noise mixed in.
  task automatic test_random_traffic(int count);
    int                           target;
    int                           pick;
    int                           group;
    logic [dots_pkg::ID_W-1:0]    id;
    logic [dots_pkg::DELAY_W-1:0] d;
    dots_pkg::op_t                op;
    target  = items_sent + count;
    wall_ms = dots_pkg::NOW_W'({$urandom, $urandom});
    while (items_sent < target) begin
      pick    = $urandom_range(0, 99);
      wall_ms = wall_ms + dots_pkg::NOW_W'($urandom_range(0, 40));
      id      = dots_pkg::ID_W'($urandom_range(0, 15));
      if (pick < 60) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = dots_pkg::OP_ARM;
          4, 5:       op = dots_pkg::OP_CANCEL;
          6, 7, 8:    op = dots_pkg::OP_TICK;
          default:    op = dots_pkg::OP_QUERY;
        endcase
        case ($urandom_range(0, 9))
          0:       d = '0;
          1:       d = $urandom;
          default: d = $urandom_range(0, 150);
        endcase
        send_timer_op(op, id, d, wall_ms);
      end else if (pick < 75) begin
        group = $urandom_range(2, 5);
        d     = $urandom_range(0, 60);
        repeat (group)
          send_timer_op(dots_pkg::OP_ARM, dots_pkg::ID_W'($urandom_range(0, 15)), d, wall_ms);
        wall_ms = wall_ms + dots_pkg::NOW_W'(d) + dots_pkg::NOW_W'($urandom_range(0, 5));
        send_timer_op(dots_pkg::OP_TICK, id, $urandom, wall_ms);
      end else if (pick < 87) begin
        send_timer_op(dots_pkg::op_t'($urandom_range(0, 3)), id, $urandom,
                      dots_pkg::NOW_W'({$urandom, $urandom}));
      end else begin
        send_timer_op(dots_pkg::OP_ARM, id, $urandom_range(0, 200), wall_ms);
        send_timer_op(($urandom_range(0, 1) != 0) ? dots_pkg::OP_CANCEL : dots_pkg::OP_QUERY,
                      id, $urandom, wall_ms + dots_pkg::NOW_W'($urandom_range(0, 100)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_arm_and_expiry();
    stall_style   = RX_RANDOM;
    bursty_sender = 1'b1;
    test_deadline_saturation();
    test_rearm_and_cancel();
    stall_style = RX_PERIODIC;
    test_tick_order();

    // hold the sender until the block has delivered everything
    wait_reports_drained();
    stall_style = RX_LONG;
    test_flush_all_slots();

    stall_style = RX_RANDOM;
    test_random_traffic(31);
    wait_reports_drained();
    stall_style   = RX_ALWAYS;
    bursty_sender = 1'b0;
    test_random_traffic(31);
    stall_style   = RX_LONG;
    bursty_sender = 1'b1;
    test_random_traffic(31);

    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("deadline_ordered_timer_set regression: pass");
    end else begin
      $display("deadline_ordered_timer_set regression: fail");
    end
    $finish;
  end

endmodule
